[rtl/tpa_pkg.sv]
// Package for the triangle primitive assembler: codes, defaults and the
// queue entry passed from the front end to the back end.
// No dependencies.
package tpa_pkg;

   localparam int INDEX_BITS_DEFAULT  = 32;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int CSR_INDEX_BITS      = 2;

   // Topology codes; the unused code 7 falls to the default arm
   typedef enum logic [2:0] {
      TOPO_LIST       = 3'd0,
      TOPO_STRIP      = 3'd1,
      TOPO_FAN        = 3'd2,
      TOPO_POINTS     = 3'd3,
      TOPO_LINES      = 3'd4,
      TOPO_LINE_LOOP  = 3'd5,
      TOPO_LINE_STRIP = 3'd6
   } topology_type;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_TRIANGLE  = 2'd0,
      KIND_DONE      = 2'd1,
      KIND_BAD_COUNT = 2'd2,
      KIND_IGNORED   = 2'd3
   } kind_type;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_TOPOLOGY     = 2'd0,
      REG_FIRST_VERTEX = 2'd1,
      REG_BASE_VERTEX  = 2'd2
   } reg_index_type;

   // One accepted item's work: an optional kept triangle, then an optional status
   typedef struct packed {
      logic        tri_keep;
      logic [31:0] corner_a;
      logic [31:0] corner_b;
      logic [31:0] corner_c;
      logic        stat_keep;
      kind_type    stat_kind;
   } entry_type;

endpackage

[rtl/tpa_if.sv]
// Channel interfaces of the triangle primitive assembler: index input,
// result output and configuration write. Depends on tpa_pkg.
interface tpa_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] vertex_index;
   logic        end_of_primitive;
   modport source (output valid, vertex_index, end_of_primitive, input ready);
   modport sink (input valid, vertex_index, end_of_primitive, output ready);
endinterface

interface tpa_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] corner_a;
   logic [31:0] corner_b;
   logic [31:0] corner_c;
   logic [1:0]  kind;
   logic        last;
   modport source (output valid, corner_a, corner_b, corner_c, kind, last, input ready);
   modport sink (input valid, corner_a, corner_b, corner_c, kind, last, output ready);
endinterface

interface tpa_csr_if;
   logic                              valid;
   logic                              ready;
   logic [tpa_pkg::CSR_INDEX_BITS-1:0] index;
   logic [31:0]                       data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[rtl/triangle_primitive_assembler_core.sv]
// Top level of the triangle primitive assembler: front end, entry queue,
// back end. Depends on tpa_pkg, tpa_if, tpa_front, tpa_queue, tpa_back.
//
//   channel  dir  handshake      payload
//   req_ch   in   valid/ready    vertex_index[31:0], end_of_primitive
//   rsp_ch   out  valid/ready    corner_a/b/c[31:0], kind[1:0], last
//   csr_ch   in   valid/ready    index[1:0], data[31:0]
//
// One item is accepted per cycle while the queue has room; the rebase add
// and assembly compare sit in the front end before the queue.
// Results leave at one per cycle through the output register unless the
// receiver stalls; an item that closes a kept triangle and ends the
// primitive gives two results, the triangle and then its status.
// Reset is synchronous; csr writes are always taken.
module triangle_primitive_assembler_core #(
   parameter int INDEX_BITS  = tpa_pkg::INDEX_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = tpa_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   tpa_req_if.sink    req_ch,
   tpa_rsp_if.source  rsp_ch,
   tpa_csr_if.sink    csr_ch
);

   logic               push;
   logic               push_ready;
   tpa_pkg::entry_type push_entry;
   logic               pop;
   logic               head_valid;
   tpa_pkg::entry_type head_entry;

   // Accept, rebase, classify
   tpa_front #(.INDEX_BITS(INDEX_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_ch     (csr_ch),
      .push_ready (push_ready),
      .push       (push),
      .push_entry (push_entry)
   );

   // Decoupling queue
   tpa_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // Result emission
   tpa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

[rtl/tpa_front.sv]
// Front end: configuration registers, index rebasing and assembly state.
// Classifies each item into a queue entry. Depends on tpa_pkg, tpa_if.
module tpa_front #(
   parameter int INDEX_BITS = tpa_pkg::INDEX_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   tpa_req_if.sink            req_ch,
   tpa_csr_if.sink            csr_ch,
   input  logic               push_ready,
   output logic               push,
   output tpa_pkg::entry_type push_entry
);

   typedef logic [INDEX_BITS-1:0] idx_type;

   // Configuration registers
   tpa_pkg::topology_type topology_ff;
   logic [31:0]           first_vertex_ff;
   logic [31:0]           base_vertex_ff;

   // Assembly state
   idx_type    older_ff, older_in;
   idx_type    newer_ff, newer_in;
   idx_type    center_ff, center_in;
   logic [1:0] seen_ff, seen_in;
   logic [1:0] phase_ff, phase_in;
   logic       parity_ff, parity_in;

   logic               accept;
   logic [31:0]        rebased;
   idx_type            local_idx;
   logic               tri_hit;
   idx_type            tri_a, tri_b, tri_c;
   tpa_pkg::kind_type  status;

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = push_ready;
   assign accept       = req_ch.valid && push_ready;

   // Configuration writes; indexes past the list are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         topology_ff     <= tpa_pkg::TOPO_LIST;
         first_vertex_ff <= 32'd0;
         base_vertex_ff  <= 32'd0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            tpa_pkg::REG_TOPOLOGY:     topology_ff     <= tpa_pkg::topology_type'(csr_ch.data[2:0]);
            tpa_pkg::REG_FIRST_VERTEX: first_vertex_ff <= csr_ch.data;
            tpa_pkg::REG_BASE_VERTEX:  base_vertex_ff  <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // Rebase to a local index, wrapping at the index width
   assign rebased   = base_vertex_ff + (req_ch.vertex_index - first_vertex_ff);
   assign local_idx = rebased[INDEX_BITS-1:0];

   // Per-topology assembly
   always_comb begin
      older_in  = older_ff;
      newer_in  = newer_ff;
      center_in = center_ff;
      seen_in   = seen_ff;
      phase_in  = phase_ff;
      parity_in = parity_ff;
      tri_hit   = 1'b0;
      tri_a     = older_ff;
      tri_b     = newer_ff;
      tri_c     = local_idx;
      status    = tpa_pkg::KIND_DONE;
      case (topology_ff)
         tpa_pkg::TOPO_LIST: begin
            if (phase_ff == 2'd0) begin
               older_in = local_idx;
               phase_in = 2'd1;
            end else if (phase_ff == 2'd1) begin
               newer_in = local_idx;
               phase_in = 2'd2;
            end else begin
               tri_hit  = 1'b1;
               phase_in = 2'd0;
            end
            if (phase_in != 2'd0) status = tpa_pkg::KIND_BAD_COUNT;
         end
         tpa_pkg::TOPO_STRIP: begin
            if (seen_ff >= 2'd2) begin
               tri_hit   = 1'b1;
               parity_in = ~parity_ff;
               if (parity_ff) begin
                  tri_a = newer_ff;
                  tri_b = older_ff;
               end
            end else begin
               seen_in = seen_ff + 2'd1;
            end
            older_in = newer_ff;
            newer_in = local_idx;
         end
         tpa_pkg::TOPO_FAN: begin
            tri_a = center_ff;
            if (seen_ff == 2'd0) begin
               center_in = local_idx;
               seen_in   = 2'd1;
            end else if (seen_ff == 2'd1) begin
               newer_in = local_idx;
               seen_in  = 2'd2;
            end else begin
               tri_hit  = 1'b1;
               newer_in = local_idx;
            end
         end
         default: status = tpa_pkg::KIND_IGNORED;
      endcase
      // End of primitive clears all state
      if (req_ch.end_of_primitive) begin
         older_in  = '0;
         newer_in  = '0;
         center_in = '0;
         seen_in   = 2'd0;
         phase_in  = 2'd0;
         parity_in = 1'b0;
      end
   end

   // Queue entry; degenerate triangles are dropped
   always_comb begin
      push_entry.tri_keep  = tri_hit && (tri_a != tri_b) && (tri_b != tri_c)
                             && (tri_a != tri_c);
      push_entry.corner_a  = 32'(tri_a);
      push_entry.corner_b  = 32'(tri_b);
      push_entry.corner_c  = 32'(tri_c);
      push_entry.stat_keep = req_ch.end_of_primitive;
      push_entry.stat_kind = status;
   end

   assign push = accept && (push_entry.tri_keep || push_entry.stat_keep);

   // State update on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         older_ff  <= '0;
         newer_ff  <= '0;
         center_ff <= '0;
         seen_ff   <= 2'd0;
         phase_ff  <= 2'd0;
         parity_ff <= 1'b0;
      end else if (accept) begin
         older_ff  <= older_in;
         newer_ff  <= newer_in;
         center_ff <= center_in;
         seen_ff   <= seen_in;
         phase_ff  <= phase_in;
         parity_ff <= parity_in;
      end
   end

endmodule

[rtl/tpa_queue.sv]
// Short queue of classified entries between front and back end.
// Depends on tpa_pkg.
module tpa_queue #(
   parameter int DEPTH = tpa_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tpa_pkg::entry_type push_entry,
   output logic               push_ready,
   input  logic               pop,
   output logic               head_valid,
   output tpa_pkg::entry_type head_entry
);

   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   tpa_pkg::entry_type        store_ff [DEPTH];
   logic [PTR_BITS-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0]     count_ff, count_in;

   assign push_ready = (count_ff < COUNT_BITS'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = store_ff[rd_ptr_ff];

   // Pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) store_ff[wr_ptr_ff] <= push_entry;
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(DEPTH))
      else $error("queue occupancy above depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < COUNT_BITS'(DEPTH)))
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("pop from empty queue");
`endif

endmodule

[rtl/tpa_back.sv]
// Back end: turns queue entries into result items through an output
// register, one result per cycle while the receiver is ready. Depends on tpa_pkg, tpa_if.
module tpa_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  tpa_pkg::entry_type head_entry,
   output logic               pop,
   tpa_rsp_if.source          rsp_ch
);

   logic        valid_ff, valid_in;
   logic        sub_ff, sub_in;
   logic [31:0] corner_a_ff, corner_a_in;
   logic [31:0] corner_b_ff, corner_b_in;
   logic [31:0] corner_c_ff, corner_c_in;
   logic [1:0]  kind_ff, kind_in;
   logic        last_ff, last_in;
   logic        load;

   assign load = !valid_ff || rsp_ch.ready;

   // Pick the triangle first, then the status of the same entry
   always_comb begin
      valid_in    = valid_ff;
      sub_in      = sub_ff;
      pop         = 1'b0;
      corner_a_in = corner_a_ff;
      corner_b_in = corner_b_ff;
      corner_c_in = corner_c_ff;
      kind_in     = kind_ff;
      last_in     = last_ff;
      if (load) begin
         valid_in = head_valid;
         if (head_valid) begin
            if (head_entry.tri_keep && !sub_ff) begin
               corner_a_in = head_entry.corner_a;
               corner_b_in = head_entry.corner_b;
               corner_c_in = head_entry.corner_c;
               kind_in     = tpa_pkg::KIND_TRIANGLE;
               last_in     = !head_entry.stat_keep;
               sub_in      = head_entry.stat_keep;
               pop         = !head_entry.stat_keep;
            end else begin
               corner_a_in = 32'd0;
               corner_b_in = 32'd0;
               corner_c_in = 32'd0;
               kind_in     = head_entry.stat_kind;
               last_in     = 1'b1;
               sub_in      = 1'b0;
               pop         = 1'b1;
            end
         end
      end
   end

   // Output register control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sub_ff   <= sub_in;
      end
   end

   // Output register payload
   always_ff @(posedge clock) begin
      corner_a_ff <= corner_a_in;
      corner_b_ff <= corner_b_in;
      corner_c_ff <= corner_c_in;
      kind_ff     <= kind_in;
      last_ff     <= last_in;
   end

   assign rsp_ch.valid    = valid_ff;
   assign rsp_ch.corner_a = corner_a_ff;
   assign rsp_ch.corner_b = corner_b_ff;
   assign rsp_ch.corner_c = corner_c_ff;
   assign rsp_ch.kind     = kind_ff;
   assign rsp_ch.last     = last_ff;

`ifndef SYNTH
   a_entry_nonempty: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (head_entry.tri_keep || head_entry.stat_keep))
      else $error("empty entry in queue");
   a_status_pending_entry: assert property (@(posedge clock) disable iff (reset)
      sub_ff |-> (head_valid && head_entry.stat_keep))
      else $error("pending status without its entry");
   a_status_after_triangle: assert property (@(posedge clock) disable iff (reset)
      sub_ff |-> (valid_ff && !last_ff))
      else $error("pending status without preceding triangle");
`endif

endmodule

[verif/triangle_primitive_assembler_core_tb.sv]
// Testbench for triangle_primitive_assembler_core: directed and random index streams
// checked item by item against an in-bench model of list, strip and fan assembly.
// Depends on tpa_pkg, tpa_if and the core RTL.
module triangle_primitive_assembler_core_tb;
   import tpa_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 16;
   localparam int ITEMS_PER_MODE = 300;

   // Expected triangles and status items, kept in order of arrival
   class assembly_checker;
      typedef struct {
         logic [31:0] a;
         logic [31:0] b;
         logic [31:0] c;
         kind_type    kind;
         logic        last;
      } corner_set_type;

      logic [2:0]     topo;
      logic [31:0]    first_vertex;
      logic [31:0]    base_vertex;
      logic [31:0]    older;
      logic [31:0]    newer;
      logic [31:0]    center;
      int unsigned    seen;
      int unsigned    list_step;
      bit             parity;
      corner_set_type expected[$];
      corner_set_type step_out[$];
      int             mismatches;

      function new();
         topo = '0;
         first_vertex = '0;
         base_vertex = '0;
         mismatches = 0;
         clear_assembly();
      endfunction

      function void clear_assembly();
         older = '0;
         newer = '0;
         center = '0;
         seen = 0;
         list_step = 0;
         parity = 1'b0;
      endfunction

      function void set_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [31:0] d);
         case (idx)
            REG_TOPOLOGY:     topo = d[2:0];
            REG_FIRST_VERTEX: first_vertex = d;
            REG_BASE_VERTEX:  base_vertex = d;
            default: ;
         endcase
      endfunction

      function void emit(logic [31:0] a, logic [31:0] b, logic [31:0] c, kind_type k);
         corner_set_type r;
         r.a = a;
         r.b = b;
         r.c = c;
         r.kind = k;
         r.last = 1'b0;
         step_out = {step_out, r};
      endfunction

      // Degenerate triangles are dropped
      function void keep_triangle(logic [31:0] a, logic [31:0] b, logic [31:0] c);
         if (a != b && b != c && a != c)
            emit(a, b, c, KIND_TRIANGLE);
      endfunction

      // One accepted index item: work out the results it causes
      function void note_index(logic [31:0] vidx, logic eop);
         logic [31:0]    loc;
         logic [31:0]    x;
         logic [31:0]    y;
         kind_type       status;
         corner_set_type r;
         step_out.delete();
         loc = base_vertex + (vidx - first_vertex);
         status = KIND_DONE;
         case (topo)
            TOPO_LIST: begin
               if (list_step == 0) begin
                  older = loc;
                  list_step = 1;
               end else if (list_step == 1) begin
                  newer = loc;
                  list_step = 2;
               end else begin
                  keep_triangle(older, newer, loc);
                  list_step = 0;
               end
               if (list_step != 0)
                  status = KIND_BAD_COUNT;
            end
            TOPO_STRIP: begin
               if (seen >= 2) begin
                  // odd positions swap the first two corners
                  x = parity ? newer : older;
                  y = parity ? older : newer;
                  keep_triangle(x, y, loc);
                  parity = ~parity;
               end else begin
                  seen++;
               end
               older = newer;
               newer = loc;
            end
            TOPO_FAN: begin
               if (seen == 0) begin
                  center = loc;
                  seen = 1;
               end else if (seen == 1) begin
                  newer = loc;
                  seen = 2;
               end else begin
                  keep_triangle(center, newer, loc);
                  newer = loc;
               end
            end
            default: status = KIND_IGNORED;
         endcase
         if (eop) begin
            emit('0, '0, '0, status);
            clear_assembly();
         end
         foreach (step_out[i]) begin
            r = step_out[i];
            r.last = (i == step_out.size() - 1);
            expected = {expected, r};
         end
      endfunction

      function void check_result(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                 logic [1:0] k, logic l);
         corner_set_type want;
         if (expected.size() == 0) begin
            $error("unexpected result item: kind %0d corners %h %h %h", k, a, b, c);
            mismatches++;
            return;
         end
         want = expected.pop_front();
         if (a !== want.a) begin
            $error("corner_a: expected %h, actual %h", want.a, a);
            mismatches++;
         end
         if (b !== want.b) begin
            $error("corner_b: expected %h, actual %h", want.b, b);
            mismatches++;
         end
         if (c !== want.c) begin
            $error("corner_c: expected %h, actual %h", want.c, c);
            mismatches++;
         end
         if (k !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, k);
            mismatches++;
         end
         if (l !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, l);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   tpa_req_if req_ch();
   tpa_rsp_if rsp_ch();
   tpa_csr_if csr_ch();

   triangle_primitive_assembler_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   assembly_checker sb;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          hold_len = 0;
   int          items_sent = 0;
   int          cycle_count = 0;
   logic [2:0]  cur_topo = TOPO_LIST;
   logic [31:0] cfg_first = '0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off when asked
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_len > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_len--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Monitor: check results before noting new items on the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.corner_a, rsp_ch.corner_b, rsp_ch.corner_c,
                            rsp_ch.kind, rsp_ch.last);
         if (csr_ch.valid && csr_ch.ready)
            sb.set_reg(csr_ch.index, csr_ch.data);
         if (req_ch.valid && req_ch.ready)
            sb.note_index(req_ch.vertex_index, req_ch.end_of_primitive);
      end
   end

   task automatic send_index(input logic [31:0] v, input logic e);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.vertex_index <= v;
      req_ch.end_of_primitive <= e;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Wait for every expected item, then let the pipeline settle
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.expected.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type r, input logic [31:0] d);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= r;
      csr_ch.data <= d;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
   endtask

   task automatic configure(input logic [2:0] t, input logic [31:0] f, input logic [31:0] b);
      drain();
      write_reg(REG_TOPOLOGY, {29'd0, t});
      write_reg(REG_FIRST_VERTEX, f);
      write_reg(REG_BASE_VERTEX, b);
      csr_ch.valid <= 1'b0;
      cur_topo = t;
      cfg_first = f;
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Mostly triangle topologies; the others now and then
   task automatic random_setup();
      int unsigned r;
      logic [2:0]  t;
      r = $urandom_range(9);
      if (r < 3) t = TOPO_LIST;
      else if (r < 6) t = TOPO_STRIP;
      else if (r < 9) t = TOPO_FAN;
      else t = 3'($urandom_range(3, 7));
      configure(t, pick_word(), pick_word());
   endtask

   // One primitive: usually well formed, sometimes left open or cut short
   task automatic send_primitive();
      int          len;
      bit          narrow;
      bit          close;
      logic [31:0] v;
      if (cur_topo == TOPO_LIST && $urandom_range(3) != 0)
         len = 3 * $urandom_range(1, 4);
      else
         len = $urandom_range(1, 10);
      narrow = $urandom_range(1);
      close = ($urandom_range(9) != 0);
      for (int i = 0; i < len; i++) begin
         // narrow pool near first_vertex makes degenerates likely
         v = narrow ? cfg_first + 32'($urandom_range(5)) : 32'($urandom);
         send_index(v, (i == len - 1) ? close : ($urandom_range(29) == 0));
      end
      items_sent += len;
   endtask

   initial begin
      int target;
      sb = new();
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.vertex_index <= '0;
      req_ch.end_of_primitive <= 1'b0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= REG_TOPOLOGY;
      csr_ch.data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: list with wrap, degenerate, clean end and bad count
      configure(TOPO_LIST, 32'h0000_0010, 32'hFFFF_FFF0);
      send_index(32'hFFFF_FFFF, 1'b0);
      send_index(32'h0000_0000, 1'b0);
      send_index(32'h0000_0010, 1'b0);
      send_index(32'd5, 1'b0);
      send_index(32'd5, 1'b0);
      send_index(32'd6, 1'b1);
      send_index(32'd7, 1'b0);
      send_index(32'd8, 1'b1);
      // strip with alternating winding, then a strip too short for a triangle
      configure(TOPO_STRIP, 32'hFFFF_FFFF, 32'h0000_0000);
      send_index(32'd0, 1'b0);
      send_index(32'd1, 1'b0);
      send_index(32'd2, 1'b0);
      send_index(32'd3, 1'b0);
      send_index(32'd4, 1'b1);
      send_index(32'd9, 1'b1);
      // fan, last triangle degenerate
      configure(TOPO_FAN, 32'h0000_0000, 32'h8000_0000);
      send_index(32'd0, 1'b0);
      send_index(32'd1, 1'b0);
      send_index(32'd2, 1'b0);
      send_index(32'd0, 1'b1);
      // non-triangle topologies, including the unused code
      configure(TOPO_POINTS, 32'h0000_0000, 32'h0000_0000);
      send_index(32'd4, 1'b0);
      send_index(32'd5, 1'b1);
      configure(3'd7, 32'h0000_0000, 32'h0000_0000);
      send_index(32'd6, 1'b1);
      // topology switched mid-primitive keeps the state
      configure(TOPO_LIST, 32'h0000_0000, 32'h0000_0000);
      send_index(32'd1, 1'b0);
      send_index(32'd2, 1'b0);
      configure(TOPO_STRIP, 32'h0000_0000, 32'h0000_0000);
      send_index(32'd3, 1'b1);

      // Random: no idling, sender idle, receiver stalling, both
      for (int m = 0; m < 4; m++) begin
         case (m)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
            default: begin send_idle_pct = 25; recv_stall_pct = 25; end
         endcase
         target = items_sent + ITEMS_PER_MODE;
         while (items_sent < target) begin
            random_setup();
            repeat ($urandom_range(2, 6)) send_primitive();
         end
      end

      // Receiver holds off while the sender keeps offering items
      send_idle_pct = 0;
      recv_stall_pct = 0;
      configure(TOPO_STRIP, pick_word(), pick_word());
      hold_len = 200;
      for (int i = 0; i < 40; i++)
         send_index($urandom, i == 39);

      drain();
      if (sb.mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
